// File: hdl/nmf_pkg.sv
// Shared types and constants for the 3x3 neighbour maximum filter.
// No dependencies.
package nmf_pkg;

  localparam int DATA_W      = 32;
  localparam int POS_W       = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [POS_W-1:0]         GRID_RESET = 6'd32;
  localparam logic signed [DATA_W-1:0] VALUE_MIN  = 32'sh8000_0000;

  // one accepted pixel and the results it causes
  typedef struct packed {
    logic signed [DATA_W-1:0] pixel;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic [1:0]               rsel;
    logic                     f_diag;
    logic                     f_edge;
    logic                     f_flush;
  } cmd_t;

endpackage

// File: hdl/neighbour_max_filter_3x3.sv
// 3x3 neighbour maximum filter (centre excluded), top level.
// Flow: the back end writes each pixel to its row store, then forms each
// result with three column reads, a merge and an output step; queue holds 2.
// Reset: positions and control cleared, grid_size 32; row stores undefined.
// Depends on nmf_pkg, nmf_front, nmf_queue, nmf_back.
module neighbour_max_filter_3x3 import nmf_pkg::*; #(
  parameter int MAX_SIZE = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [POS_W-1:0]         grid_size,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] pixel_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] max_value,
  output logic [POS_W-1:0]         out_row,
  output logic [POS_W-1:0]         out_col,
  output logic                     last_of_run
);

  logic [POS_W-1:0] grid;
  logic [POS_W-1:0] side;
  logic             cfg_write;
  logic             push;
  cmd_t             push_cmd;
  logic             q_full;
  logic             q_empty;
  logic             pop;
  cmd_t             q_cmd;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign side      = (grid == '0) ? POS_W'(1) :
                     ((grid > POS_W'(MAX_SIZE)) ? POS_W'(MAX_SIZE) : grid);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid <= GRID_RESET;
    end else if (cfg_write) begin
      grid <= grid_size;
    end
  end

  nmf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_value (pixel_value),
    .side        (side),
    .cfg_write   (cfg_write),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  nmf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .pop_cmd  (q_cmd)
  );

  nmf_back #(.MAX_SIZE(MAX_SIZE)) u_back (
    .clk         (clk),
    .rst         (rst),
    .side        (side),
    .q_empty     (q_empty),
    .q_cmd       (q_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .max_value   (max_value),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run)
  );

endmodule

// File: hdl/nmf_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module nmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/nmf_queue.sv
// Short command queue between the front and back ends.
// Depends on nmf_pkg.
module nmf_queue import nmf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t pop_cmd
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/nmf_front.sv
// Front end: accepts pixels, tracks the frame position and classifies
// which results each pixel releases. Depends on nmf_pkg.
module nmf_front import nmf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] pixel_value,
  input  logic [POS_W-1:0]         side,
  input  logic                     cfg_write,
  input  logic                     q_full,
  output logic                     push,
  output cmd_t                     push_cmd
);

  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;
  logic [1:0]       rsel;
  logic [POS_W-1:0] r_eff;
  logic [POS_W-1:0] c_eff;
  logic [1:0]       s_eff;
  logic [POS_W-1:0] last;
  logic             wrap;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign last     = side - 1'b1;
  assign wrap     = (row >= side) || (col >= side);
  assign r_eff    = wrap ? '0 : row;
  assign c_eff    = wrap ? '0 : col;
  assign s_eff    = wrap ? 2'd0 : rsel;

  always_comb begin
    push_cmd.pixel   = pixel_value;
    push_cmd.row     = r_eff;
    push_cmd.col     = c_eff;
    push_cmd.rsel    = s_eff;
    push_cmd.f_diag  = (r_eff != '0) && (c_eff != '0);
    push_cmd.f_edge  = (r_eff != '0) && (c_eff == last);
    push_cmd.f_flush = (r_eff == last) && (c_eff == last);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      row  <= '0;
      col  <= '0;
      rsel <= 2'd0;
    end else if (push) begin
      if (c_eff == last) begin
        col <= '0;
        if (r_eff == last) begin
          row  <= '0;
          rsel <= 2'd0;
        end else begin
          row  <= r_eff + 1'b1;
          rsel <= (s_eff == 2'd2) ? 2'd0 : s_eff + 2'd1;
        end
      end else begin
        row  <= r_eff;
        col  <= c_eff + 1'b1;
        rsel <= s_eff;
      end
    end
  end

endmodule

// File: hdl/nmf_back.sv
// Back end: writes each pixel to its row store, then forms every result by
// reading three columns from the three row stores. Depends on nmf_pkg, nmf_ram.
module nmf_back import nmf_pkg::*; #(
  parameter int MAX_SIZE = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [POS_W-1:0]         side,
  input  logic                     q_empty,
  input  cmd_t                     q_cmd,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] max_value,
  output logic [POS_W-1:0]         out_row,
  output logic [POS_W-1:0]         out_col,
  output logic                     last_of_run
);

  localparam int AW = $clog2(MAX_SIZE);

  typedef enum logic [2:0] {S_IDLE, S_WRITE, S_READ, S_DRAIN, S_PUT} state_t;
  typedef enum logic [1:0] {P_DIAG, P_EDGE, P_FLUSH} phase_t;

  function automatic logic [1:0] inc3(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] dec3(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic signed [DATA_W-1:0] smax(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  state_t                   state;
  phase_t                   phase;
  cmd_t                     cmd;
  logic [POS_W-1:0]         fcol;
  logic [1:0]               k;
  logic                     pend_live;
  logic                     pend_ok;
  logic                     pend_centre;
  logic signed [DATA_W-1:0] acc;

  logic [POS_W-1:0]         ti;
  logic [POS_W-1:0]         tj;
  logic [1:0]               msel;
  logic [1:0]               usel;
  logic [1:0]               dsel;
  logic                     up_ok;
  logic                     down_ok;
  logic [POS_W:0]           colx;
  logic [POS_W:0]           colm1;
  logic                     col_ok;
  logic [AW-1:0]            raddr;
  logic [DATA_W-1:0]        rd [3];
  logic [2:0]               we;
  logic signed [DATA_W-1:0] up_m;
  logic signed [DATA_W-1:0] mid_m;
  logic signed [DATA_W-1:0] down_m;
  logic signed [DATA_W-1:0] acc_next;
  logic                     has_next;
  phase_t                   phase_next;
  logic [POS_W-1:0]         fcol_next;
  logic                     has_first;
  phase_t                   phase_first;
  logic                     out_free;

  for (genvar g = 0; g < 3; g++) begin : g_store
    nmf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE)) u_ram (
      .clk   (clk),
      .we    (we[g]),
      .waddr (cmd.col[AW-1:0]),
      .wdata (cmd.pixel),
      .raddr (raddr),
      .rdata (rd[g])
    );
  end

  assign pop      = (state == S_IDLE) && !q_empty;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    we = 3'b000;
    if (state == S_WRITE) begin
      we[cmd.rsel] = 1'b1;
    end
  end

  always_comb begin
    unique case (phase)
      P_DIAG: begin
        ti   = cmd.row - 1'b1;
        tj   = cmd.col - 1'b1;
        msel = dec3(cmd.rsel);
      end
      P_EDGE: begin
        ti   = cmd.row - 1'b1;
        tj   = side - 1'b1;
        msel = dec3(cmd.rsel);
      end
      P_FLUSH: begin
        ti   = cmd.row;
        tj   = fcol;
        msel = cmd.rsel;
      end
      default: begin
        ti   = cmd.row;
        tj   = fcol;
        msel = cmd.rsel;
      end
    endcase
    usel    = dec3(msel);
    dsel    = inc3(msel);
    up_ok   = (ti != '0);
    down_ok = (ti != side - 1'b1);
    colx    = {1'b0, tj} + (POS_W + 1)'(k);
    colm1   = colx - 1'b1;
    col_ok  = (colx != '0) && (colx <= {1'b0, side});
    raddr   = colm1[AW-1:0];
  end

  always_comb begin
    up_m     = (pend_ok && up_ok) ? $signed(rd[usel]) : VALUE_MIN;
    mid_m    = (pend_ok && !pend_centre) ? $signed(rd[msel]) : VALUE_MIN;
    down_m   = (pend_ok && down_ok) ? $signed(rd[dsel]) : VALUE_MIN;
    acc_next = smax(smax(up_m, mid_m), smax(down_m, acc));
  end

  always_comb begin
    has_next   = 1'b0;
    phase_next = P_FLUSH;
    fcol_next  = '0;
    unique case (phase)
      P_DIAG: begin
        if (cmd.f_edge) begin
          has_next   = 1'b1;
          phase_next = P_EDGE;
        end else if (cmd.f_flush) begin
          has_next = 1'b1;
        end
      end
      P_EDGE: has_next = cmd.f_flush;
      P_FLUSH: begin
        has_next  = (fcol != side - 1'b1);
        fcol_next = fcol + 1'b1;
      end
      default: has_next = 1'b0;
    endcase
    has_first   = cmd.f_diag || cmd.f_edge || cmd.f_flush;
    phase_first = cmd.f_diag ? P_DIAG : (cmd.f_edge ? P_EDGE : P_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= P_DIAG;
      fcol        <= '0;
      k           <= 2'd0;
      pend_live   <= 1'b0;
      pend_ok     <= 1'b0;
      pend_centre <= 1'b0;
      acc         <= VALUE_MIN;
      out_valid   <= 1'b0;
      max_value   <= VALUE_MIN;
      out_row     <= '0;
      out_col     <= '0;
      last_of_run <= 1'b0;
      cmd         <= '0;
    end else begin
      if (out_valid && !out_stall && (state != S_PUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cmd   <= q_cmd;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          acc       <= VALUE_MIN;
          k         <= 2'd0;
          fcol      <= '0;
          pend_live <= 1'b0;
          phase     <= phase_first;
          state     <= has_first ? S_READ : S_IDLE;
        end
        S_READ: begin
          if (pend_live) begin
            acc <= acc_next;
          end
          pend_live   <= 1'b1;
          pend_ok     <= col_ok;
          pend_centre <= (k == 2'd1);
          k           <= k + 2'd1;
          if (k == 2'd2) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          acc       <= acc_next;
          pend_live <= 1'b0;
          state     <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            max_value   <= acc;
            out_row     <= ti;
            out_col     <= tj;
            last_of_run <= !has_next;
            if (has_next) begin
              phase <= phase_next;
              fcol  <= fcol_next;
              acc   <= VALUE_MIN;
              k     <= 2'd0;
              state <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: test/tb_neighbour_max_filter_3x3.sv
`timescale 1ns / 1ps
// Testbench for neighbour_max_filter_3x3: streams pixel frames of several sizes,
// predicts each neighbour maximum and checks every result in order.
// Depends on nmf_pkg and the neighbour_max_filter_3x3 RTL.
module tb_neighbour_max_filter_3x3;
  import nmf_pkg::*;

  localparam int FRAME_MAX = 32;
  localparam int SETTLE    = 40;

  typedef struct packed {
    logic signed [DATA_W-1:0] maxv;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic                     last;
  } nbr_result_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [POS_W-1:0]         grid_size;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] pixel_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] max_value;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_col;
  logic                     last_of_run;

  // predictor state
  logic signed [DATA_W-1:0] line_mem [3][FRAME_MAX];
  logic [POS_W-1:0]         grid_reg;
  int                       cur_row;
  int                       cur_col;
  nbr_result_t              max_fifo[$];

  int errors;
  bit in_idle_on;
  bit out_idle_on;

  neighbour_max_filter_3x3 #(.MAX_SIZE(FRAME_MAX)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .grid_size   (grid_size),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_value (pixel_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .max_value   (max_value),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("neighbour_max_filter_3x3 test failed");
    $finish;
  end

  function automatic int frame_side();
    int g;
    g = grid_reg;
    if (g == 0) g = 1;
    if (g > FRAME_MAX) g = FRAME_MAX;
    return g;
  endfunction

  function automatic logic signed [DATA_W-1:0] window_max(input int i, input int j,
                                                          input int n);
    logic signed [DATA_W-1:0] best;
    int rr;
    int cc;
    best = VALUE_MIN;
    for (rr = i - 1; rr <= i + 1; rr++)
      for (cc = j - 1; cc <= j + 1; cc++)
        if (!(rr == i && cc == j) && rr >= 0 && rr < n && cc >= 0 && cc < n)
          if (line_mem[rr % 3][cc] > best) best = line_mem[rr % 3][cc];
    return best;
  endfunction

  task automatic queue_result(input int i, input int j, input int n, input bit last);
    nbr_result_t e;
    e.maxv = window_max(i, j, n);
    e.row  = POS_W'(i);
    e.col  = POS_W'(j);
    e.last = last;
    max_fifo.push_back(e);
  endtask

  task automatic predict_pixel(input logic signed [DATA_W-1:0] v);
    int n;
    int r;
    int c;
    int total;
    int k;
    int j;
    n = frame_side();
    r = cur_row;
    c = cur_col;
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
    end
    line_mem[r % 3][c] = v;
    total = 0;
    if (r >= 1 && c >= 1) total++;
    if (r >= 1 && c == n - 1) total++;
    if (r == n - 1 && c == n - 1) total += n;
    k = 0;
    if (r >= 1 && c >= 1) begin
      k++;
      queue_result(r - 1, c - 1, n, k == total);
    end
    if (r >= 1 && c == n - 1) begin
      k++;
      queue_result(r - 1, n - 1, n, k == total);
    end
    if (r == n - 1 && c == n - 1) begin
      for (j = 0; j < n; j++) begin
        k++;
        queue_result(r, j, n, k == total);
      end
    end
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endtask

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return VALUE_MIN;
      1:       return 32'sh7fff_ffff;
      2, 3:    return $signed($urandom_range(0, 6)) - 3;
      default: return $signed($urandom);
    endcase
  endfunction

  // one pixel request; returns at the accepting edge
  task automatic send_pixel(input logic signed [DATA_W-1:0] v);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= v;
    do begin
      @(posedge clk);
    end while (in_stall);
    predict_pixel(v);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (max_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_grid(input logic [POS_W-1:0] g);
    drain_results();
    cfg_valid <= 1'b1;
    grid_size <= g;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    grid_reg = g;
    cur_row  = 0;
    cur_col  = 0;
  endtask

  task automatic send_frame(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      send_pixel(rand_pixel());
      if ($urandom_range(0, 60) == 0) drain_results();
    end
  endtask

  // output side back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (out_idle_on) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    nbr_result_t got;
    nbr_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got.maxv = max_value;
      got.row  = out_row;
      got.col  = out_col;
      got.last = last_of_run;
      if (max_fifo.size() == 0) begin
        note_error($sformatf("unexpected result: max %0d row %0d col %0d last %0b",
                             got.maxv, got.row, got.col, got.last));
      end else begin
        want = max_fifo.pop_front();
        if (got !== want)
          note_error($sformatf(
            "mismatch: exp max %0d row %0d col %0d last %0b, got max %0d row %0d col %0d last %0b",
            want.maxv, want.row, want.col, want.last,
            got.maxv, got.row, got.col, got.last));
      end
    end
  end

  // partial frame at the reset size
  task automatic test_default_size();
    send_frame(34);
  endtask

  task automatic test_single_pixel_frame();
    write_grid(6'd1);
    send_pixel(32'sh7fff_ffff);
    send_pixel(VALUE_MIN);
    send_pixel(32'sd0);
    send_pixel(-32'sd1);
    write_grid(6'd0);
    send_pixel(32'sh7fff_ffff);
    send_pixel(32'sd5);
  endtask

  task automatic test_small_extremes();
    write_grid(6'd2);
    send_pixel(32'sh7fff_ffff);
    send_pixel(VALUE_MIN);
    send_pixel(VALUE_MIN);
    send_pixel(32'sh7fff_ffff);
    write_grid(6'd3);
    send_pixel(VALUE_MIN);
    send_pixel(32'sh7fff_ffff);
    send_pixel(VALUE_MIN);
    send_pixel(-32'sd1);
    send_pixel(32'sh7fff_ffff);
    send_pixel(32'sd0);
    send_pixel(VALUE_MIN);
    send_pixel(32'sd1);
    send_pixel(VALUE_MIN);
  endtask

  // oversize settings saturate to the row store depth
  task automatic test_large_frames();
    write_grid(6'd63);
    send_frame(66);
    write_grid(6'd33);
    send_frame(34);
  endtask

  task automatic test_random_frames(input int target);
    int sent;
    int n;
    int frames;
    int count;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(0, 9))
        0:       n = 1;
        1:       n = $urandom_range(9, 12);
        default: n = $urandom_range(2, 8);
      endcase
      write_grid(POS_W'(n));
      frames = $urandom_range(1, 2);
      repeat (frames) begin
        count = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n * n) : n * n;
        send_frame(count);
        sent += count;
      end
    end
  endtask

  task automatic test_streaming();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    write_grid(6'd5);
    send_frame(25);
    send_frame(25);
  endtask

  initial begin
    int waited;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    grid_size   = '0;
    in_valid    = 1'b0;
    pixel_value = '0;
    errors      = 0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    grid_reg    = GRID_RESET;
    cur_row     = 0;
    cur_col     = 0;
    foreach (line_mem[a, b]) line_mem[a][b] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_size();
    test_single_pixel_frame();
    test_small_extremes();
    test_large_frames();
    test_random_frames(40);
    test_streaming();

    in_valid <= 1'b0;
    waited = 0;
    while (max_fifo.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (max_fifo.size() != 0)
      note_error($sformatf("%0d expected results never arrived", max_fifo.size()));

    if (errors == 0) begin
      $display("neighbour_max_filter_3x3 test passed");
    end else begin
      $display("neighbour_max_filter_3x3 test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/nmf_pkg.sv
hdl/nmf_ram.sv
hdl/nmf_queue.sv
hdl/nmf_front.sv
hdl/nmf_back.sv
hdl/neighbour_max_filter_3x3.sv
test/tb_neighbour_max_filter_3x3.sv
